[sv/first_fit_block_allocator_unit_assert.svh]
// ----------------------------------------------------------------------------
// first fit block allocator assertion macros
// concurrent assertion wrappers for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define FFBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first fit block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffba_pkg;

	// heap address span in bits, the limit is clamped to 2**HEAP_ADDR_BITS
	localparam int HEAP_ADDR_BITS = 20;

	localparam int REQ_W   = 20;
	localparam int ADDR_W  = 20;
	localparam int LIMIT_W = 21;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'h10_0000;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NULL    = 3'd1,
		ST_NOSPACE = 3'd2,
		ST_FULL    = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
		logic deliver;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic done;
	} sts_t;

endpackage

[sv/ffba_if.sv]
// ----------------------------------------------------------------------------
// ffba channel interfaces
// valid/ready channels for requests, results and the limit register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ffba_cmd_if;
	logic                          valid;
	logic                          ready;
	ffba_pkg::op_t                 op;
	logic [ffba_pkg::REQ_W-1:0]    req_size;
	logic [ffba_pkg::ADDR_W-1:0]   free_addr;

	modport source (output valid, output op, output req_size, output free_addr, input ready);
	modport sink   (input valid, input op, input req_size, input free_addr, output ready);
endinterface

interface ffba_rsp_if;
	logic                          valid;
	logic                          ready;
	ffba_pkg::status_t             status;
	logic [ffba_pkg::ADDR_W-1:0]   addr;
	logic                          reused;
	logic                          released;

	modport source (output valid, output status, output addr, output reused,
		output released, input ready);
	modport sink   (input valid, input status, input addr, input reused,
		input released, output ready);
endinterface

interface ffba_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ffba_pkg::LIMIT_W-1:0]  heap_limit;

	modport source (output valid, output heap_limit, input ready);
	modport sink   (input valid, input heap_limit, output ready);
endinterface

[sv/ffba_controller.sv]
// ----------------------------------------------------------------------------
// ffba_controller
// sequences accept, table scan, commit and result hand-over
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  ffba_pkg::sts_t sts,
	output ffba_pkg::ctl_t ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		ctl.start   = (state_q == S_IDLE) && cmd_valid;
		ctl.scan    = (state_q == S_SCAN);
		ctl.commit  = (state_q == S_SCAN) && sts.done;
		ctl.deliver = (state_q == S_HOLD) && (!out_valid_q || rsp_ready);
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.done) state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (ctl.deliver) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			if (ctl.deliver) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/ffba_datapath.sv]
// ----------------------------------------------------------------------------
// ffba_datapath
// block table memory, scan pipeline, break and count registers, results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_datapath #(
	parameter int MAX_BLOCKS     = 64,
	parameter int HEADER_BYTES   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffba_pkg::ctl_t                ctl,
	output ffba_pkg::sts_t                sts,
	input  ffba_pkg::op_t                 op,
	input  logic [ffba_pkg::REQ_W-1:0]    req_size,
	input  logic [ffba_pkg::ADDR_W-1:0]   free_addr,
	input  logic                          cfg_we,
	input  logic [ffba_pkg::LIMIT_W-1:0]  cfg_data,
	output ffba_pkg::status_t             status,
	output logic [ffba_pkg::ADDR_W-1:0]   addr,
	output logic                          reused,
	output logic                          released
);

	localparam int REQ_W   = ffba_pkg::REQ_W;
	localparam int ADDR_W  = ffba_pkg::ADDR_W;
	localparam int LIMIT_W = ffba_pkg::LIMIT_W;
	localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
	localparam int HDR_W   = $clog2(HEADER_BYTES + 1);
	localparam int NEED_W  = LIMIT_W + 2;

	localparam logic [HDR_W-1:0] HDR     = HDR_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
	localparam logic [32:0]      SPAN    = 33'(1) << ffba_pkg::HEAP_ADDR_BITS;

	typedef struct packed {
		logic               free;
		logic [REQ_W-1:0]   size;
		logic [LIMIT_W-1:0] start;
	} entry_t;

	entry_t mem [MAX_BLOCKS];

	ffba_pkg::op_t        op_q;
	logic [REQ_W-1:0]     req_q;
	logic [ADDR_W-1:0]    faddr_q;
	logic                 null_q;
	logic [CNT_W-1:0]     count_q;
	logic [LIMIT_W-1:0]   break_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	entry_t               ent_s1;

	ffba_pkg::status_t    res_status_q;
	logic [ADDR_W-1:0]    res_addr_q;
	logic                 res_reused_q;
	logic                 res_released_q;
	ffba_pkg::status_t    status_q;
	logic [ADDR_W-1:0]    addr_q;
	logic                 reused_q;
	logic                 released_q;

	logic                 issue;
	logic                 match;
	logic                 hit;
	logic                 last;
	logic                 nospace;
	logic                 full;
	logic [LIMIT_W:0]     hit_payload;
	logic [LIMIT_W:0]     brk_payload;
	logic [LIMIT_W:0]     lim_eff;
	logic [NEED_W-1:0]    need;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	entry_t               wr_data;
	logic                 grow;
	logic                 pop;
	ffba_pkg::status_t    n_status;
	logic [ADDR_W-1:0]    n_addr;
	logic                 n_reused;
	logic                 n_released;

	// one table read per cycle while scanning
	assign issue = ctl.scan && (rd_idx_q < count_q);

	assign hit_payload = {1'b0, ent_s1.start} + (LIMIT_W + 1)'(HDR);
	assign brk_payload = {1'b0, break_q} + (LIMIT_W + 1)'(HDR);

	always_comb begin
		if (op_q == ffba_pkg::OP_ALLOC) begin
			match = ent_s1.free && (ent_s1.size >= req_q);
		end else begin
			match = (hit_payload == (LIMIT_W + 1)'(faddr_q));
		end
	end

	assign hit  = vld_s1 && match;
	assign last = ((CNT_W'(idx_s1) + CNT_W'(1)) == count_q);

	// heap limit clamped to the address span
	always_comb begin
		if ({12'd0, limit_q} > SPAN) begin
			lim_eff = SPAN[LIMIT_W:0];
		end else begin
			lim_eff = {1'b0, limit_q};
		end
	end

	assign need    = NEED_W'(break_q) + NEED_W'(HDR) + NEED_W'(req_q);
	assign nospace = (need > NEED_W'(lim_eff));
	assign full    = (count_q >= CNT_MAX);

	assign sts.done = ctl.scan && (null_q || hit || (!vld_s1 && (rd_idx_q >= count_q)));

	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = idx_s1;
		wr_data    = ent_s1;
		grow       = 1'b0;
		pop        = 1'b0;
		n_status   = ffba_pkg::ST_OK;
		n_addr     = '0;
		n_reused   = 1'b0;
		n_released = 1'b0;
		priority if (null_q) begin
			n_status = ffba_pkg::ST_NULL;
		end else if (op_q == ffba_pkg::OP_ALLOC) begin
			priority if (hit) begin
				wr_en        = 1'b1;
				wr_data.free = 1'b0;
				n_addr       = hit_payload[ADDR_W-1:0];
				n_reused     = 1'b1;
			end else if (nospace) begin
				n_status = ffba_pkg::ST_NOSPACE;
			end else if (full) begin
				n_status = ffba_pkg::ST_FULL;
			end else begin
				wr_en         = 1'b1;
				wr_idx        = count_q[IDX_W-1:0];
				wr_data.free  = 1'b0;
				wr_data.size  = req_q;
				wr_data.start = break_q;
				grow          = 1'b1;
				n_addr        = brk_payload[ADDR_W-1:0];
			end
		end else begin
			priority if (hit && last) begin
				pop        = 1'b1;
				n_released = 1'b1;
			end else if (hit) begin
				wr_en        = 1'b1;
				wr_data.free = 1'b1;
			end else begin
				n_status = ffba_pkg::ST_UNKNOWN;
			end
		end
	end

	// table memory and registered read
	always_ff @(posedge clk) begin
		if (ctl.commit && wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (issue) begin
			ent_s1 <= mem[rd_idx_q[IDX_W-1:0]];
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
	end

	// transaction fields and results
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q    <= op;
			req_q   <= req_size;
			faddr_q <= free_addr;
			null_q  <= (op == ffba_pkg::OP_ALLOC) ? (req_size == '0) : (free_addr == '0);
		end
		if (ctl.commit) begin
			res_status_q   <= n_status;
			res_addr_q     <= n_addr;
			res_reused_q   <= n_reused;
			res_released_q <= n_released;
		end
		if (ctl.deliver) begin
			status_q   <= res_status_q;
			addr_q     <= res_addr_q;
			reused_q   <= res_reused_q;
			released_q <= res_released_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			break_q  <= '0;
			limit_q  <= ffba_pkg::LIMIT_RESET;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (ctl.start) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (ctl.commit && grow) begin
				count_q <= count_q + CNT_W'(1);
				break_q <= need[LIMIT_W-1:0];
			end else if (ctl.commit && pop) begin
				count_q <= count_q - CNT_W'(1);
				break_q <= ent_s1.start;
			end
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
		end
	end

	assign status   = status_q;
	assign addr     = addr_q;
	assign reused   = reused_q;
	assign released = released_q;

endmodule

[sv/first_fit_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// first fit heap allocator with a break pointer and a block table memory
// ----------------------------------------------------------------------------
//  channel  dir   payload                              handshake
//  cmd      in    op, req_size, free_addr              cmd.valid / cmd.ready
//  rsp      out   status, addr, reused, released       rsp.valid / rsp.ready
//  cfg      in    heap_limit                           cfg.valid / cfg.ready (always 1)
//
//  one transaction at a time: a null request ends its scan at once; any other request
//  scans the block table until a hit or its last entry, through the table's single read
//  port, one entry a cycle
//  reset clears block count, break and the handshake state, loads limit with LIMIT_RESET; table is not cleared
//  a result waiting in the output register only stalls the next one at hand-over
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_block_allocator_unit_assert.svh"

module first_fit_block_allocator_unit #(
	parameter int MAX_BLOCKS     = 64,
	parameter int HEADER_BYTES   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	ffba_cmd_if.sink     cmd,
	ffba_rsp_if.source   rsp,
	ffba_cfg_if.sink     cfg
);

	ffba_pkg::ctl_t ctl;
	ffba_pkg::sts_t sts;

	// limit register never back-pressures
	assign cfg.ready = 1'b1;

	// state machine: idle, table scan, result hand-over
	ffba_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// table memory, scan compare, break arithmetic and result registers
	ffba_datapath #(
		.MAX_BLOCKS     (MAX_BLOCKS),
		.HEADER_BYTES   (HEADER_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.op        (cmd.op),
		.req_size  (cmd.req_size),
		.free_addr (cmd.free_addr),
		.cfg_we    (cfg.valid && cfg.ready),
		.cfg_data  (cfg.heap_limit),
		.status    (rsp.status),
		.addr      (rsp.addr),
		.reused    (rsp.reused),
		.released  (rsp.released)
	);

	// only one transaction in flight
	`FFBA_ASSERT_NXT(a_single_txn, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready, "busy accept")

	// the scan stops once its outcome is committed
	`FFBA_ASSERT_NXT(a_scan_ends, clk, arst_n, ctl.commit, !ctl.scan, "scan after commit")

	// a new result only appears through a hand-over
	`FFBA_ASSERT_IMP(a_rsp_from_deliver, clk, arst_n, $rose(rsp.valid), $past(ctl.deliver),
		"result raised without hand-over")

endmodule
